FILE: rtl/core/dse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dse_pkg: shared types, codes and constant tables
// Operation codes, register indexes, controller states and the elaboration
// functions that build the exp factor tables.
// ----------------------------------------------------------------------------
package dse_pkg;

	localparam int unsigned LEARN_DEPTH_DEF = 256;
	localparam int unsigned EXP_FRAC_DEF    = 256;
	localparam int unsigned Q15_ONE         = 32768;

	typedef enum logic [2:0] {
		OP_SPIKE     = 3'd0,
		OP_FIRE      = 3'd1,
		OP_WR_NEG    = 3'd2,
		OP_WR_POS    = 3'd3,
		OP_INIT      = 3'd4,
		OP_RSVD5     = 3'd5,
		OP_RSVD6     = 3'd6,
		OP_RSVD7     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_MAX_G    = 3'd1,
		REG_DEP_RATE = 3'd2,
		REG_FAC_RATE = 3'd3,
		REG_NEG_EN   = 3'd4,
		REG_POS_EN   = 3'd5,
		REG_NEG_WIN  = 3'd6,
		REG_POS_WIN  = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POS_RD,
		ST_POS_UPD,
		ST_EXP1,
		ST_EXP2,
		ST_FAC1,
		ST_FAC2,
		ST_DEP1,
		ST_DEP2,
		ST_G1,
		ST_G2
	} st_t;

	// exp(-k) in Q16 for integer part k
	function automatic logic [16:0] int_exp(input logic [3:0] k);
		logic [16:0] v;
		case (k)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd24109;
			4'd2:    v = 17'd8869;
			4'd3:    v = 17'd3263;
			4'd4:    v = 17'd1200;
			4'd5:    v = 17'd442;
			4'd6:    v = 17'd162;
			4'd7:    v = 17'd60;
			4'd8:    v = 17'd22;
			4'd9:    v = 17'd8;
			4'd10:   v = 17'd3;
			4'd11:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// shift-subtract quotient, used at elaboration only
	function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] rem;
		logic [63:0] q;
		int          j;
		rem = '0;
		q   = '0;
		for (j = 63; j >= 0; j--) begin
			rem = {rem[63:0], a[j]};
			if (rem >= {1'b0, b}) begin
				rem  = rem - {1'b0, b};
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	// entry i of the fractional exp table: exp(-i/n) in Q16
	function automatic logic [16:0] frac_entry(input int unsigned n, input int unsigned i);
		logic [63:0] sum;
		logic [63:0] term;
		logic [64:0] p;
		logic [64:0] pr;
		logic        done;
		int unsigned j;
		sum  = 64'd1 << 32;
		term = 64'd1 << 32;
		done = 1'b0;
		for (j = 1; j < 32; j++) begin
			if (!done) begin
				term = div_u64(term, 64'(n) * 64'(j));
				if (term == 64'd0)
					done = 1'b1;
				else if (j[0])
					sum = sum - term;
				else
					sum = sum + term;
			end
		end
		p = 65'd1 << 32;
		for (j = 0; j < i; j++) begin
			pr = 65'(p[63:0] * sum + (64'd1 << 31));
			if (p[32])
				pr = 65'({sum, 32'd0} + (65'd1 << 31));
			p = 65'(pr >> 32);
		end
		pr = p + 65'd32768;
		return pr[32:16];
	endfunction

	// round half away from zero, arithmetic right shift
	function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] v,
			input int unsigned s);
		logic signed [47:0] half;
		logic signed [47:0] mag;
		half = 48'sd1 <<< (s - 1);
		if (!v[47]) begin
			return (v + half) >>> s;
		end
		mag = -v;
		return -((mag + half) >>> s);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dynamic_synapse_efficacy_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dynamic_synapse_efficacy_top: short-term plastic synapse with learning
// Depression and facilitation of one synapse, conductance per spike, and
// spike-timing learning of base utilisation from two learning tables.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | contents
//  s_*      | in        | s_tvalid/s_tready  | tuser op, tdata item fields
//  m_*      | out       | m_tvalid/m_tready  | tdata conductance, use, resource
//  cfg_*    | in        | cfg_valid/cfg_ready| register index and write data
//
// A spike passes from acceptance through the exp units, then the
// facilitation, depression and conductance steps, to the output register;
// the next item is accepted once the controller is back in idle.
// Cell-fire updates the base utilisation after a learning table read; table
// writes and init complete on acceptance. One item is in flight at a time.
// The output register holds a result while m_tready is low; a new item is
// accepted meanwhile, and a following spike stalls at its last step.
// Reset clears the controller, configuration, synapse state and m_tvalid;
// datapath registers and the learning memories are unknown until written.
// ----------------------------------------------------------------------------
module dynamic_synapse_efficacy_top
	import dse_pkg::*;
#(
	parameter int unsigned LEARN_TABLE_DEPTH = LEARN_DEPTH_DEF,
	parameter int unsigned EXP_FRAC_ENTRIES  = EXP_FRAC_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	// [31:0] time_step, [63:32] last_fire_time, [71:64] table_index,
	// [87:72] table_value, [103:88] init_use, [119:104] init_resource
	input  wire logic [119:0] s_tdata,
	// [2:0] op
	input  wire logic [2:0]   s_tuser,
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	// [15:0] conductance, [31:16] effective_use, [47:32] resource_now
	output      logic [47:0]  m_tdata,
	input  wire logic         cfg_valid,
	output      logic         cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);

	localparam int unsigned AW = (LEARN_TABLE_DEPTH > 1) ? $clog2(LEARN_TABLE_DEPTH) : 1;

	// configuration
	logic [1:0]  mode_q;
	logic [15:0] max_g_q, dep_rate_q, fac_rate_q;
	logic        neg_en_q, pos_en_q;
	logic [8:0]  neg_win_q, pos_win_q;

	// synapse state
	logic [15:0] base_q, fu_q, res_q;
	logic signed [31:0] prev_q;
	logic        flag_q;

	// controller
	st_t state_q, state_d;

	// input fields
	logic signed [31:0] in_ts, in_lf;
	logic [7:0]  in_idx;
	logic [15:0] in_tv, in_iu, in_ir;
	op_t         in_op;
	logic        in_acc;

	assign in_ts  = s_tdata[31:0];
	assign in_lf  = s_tdata[63:32];
	assign in_idx = s_tdata[71:64];
	assign in_tv  = s_tdata[87:72];
	assign in_iu  = s_tdata[103:88];
	assign in_ir  = s_tdata[119:104];
	assign in_op  = op_t'(s_tuser);
	assign in_acc = s_tvalid && s_tready;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// item registers
	logic signed [31:0] ts_q;
	logic signed [32:0] dt_q, dlf_q;
	logic        neg_hit_q, pos_hit_q;

	logic signed [32:0] dt_now, dlf_now;
	assign dt_now  = 33'(in_ts) - 33'(prev_q);
	assign dlf_now = 33'(in_ts) - 33'(in_lf);

	// learning table memories
	logic signed [15:0] neg_mem [LEARN_TABLE_DEPTH];
	logic signed [15:0] pos_mem [LEARN_TABLE_DEPTH];
	logic signed [15:0] neg_rd_q, pos_rd_q;
	logic        tbl_in_range;

	assign tbl_in_range = 32'(in_idx) < 32'(LEARN_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (in_acc && in_op == OP_WR_NEG && tbl_in_range)
			neg_mem[AW'(in_idx)] <= in_tv;
		if (in_acc && in_op == OP_WR_POS && tbl_in_range)
			pos_mem[AW'(in_idx)] <= in_tv;
		if (state_q == ST_EXP1)
			neg_rd_q <= neg_mem[dlf_q[AW-1:0]];
		if (state_q == ST_POS_RD)
			pos_rd_q <= pos_mem[dt_q[AW-1:0]];
	end

	// exp factor units
	logic [16:0] ed, ef;

	dse_exp #(.EXP_FRAC_ENTRIES(EXP_FRAC_ENTRIES)) u_exp_dep (
		.clk   (clk),
		.dt    (dt_q),
		.rate  (dep_rate_q),
		.factor(ed)
	);

	dse_exp #(.EXP_FRAC_ENTRIES(EXP_FRAC_ENTRIES)) u_exp_fac (
		.clk   (clk),
		.dt    (dt_q),
		.rate  (fac_rate_q),
		.factor(ef)
	);

	// arithmetic datapath
	logic signed [19:0] af_q;
	logic signed [19:0] ad_q;
	logic [15:0] eu_q, rn_q;
	logic [31:0] p_q;

	logic signed [47:0] omu_f, af_mul, af_rnd;
	logic signed [47:0] fu_mul, fu_sum;
	logic [15:0]        fu_new;
	logic signed [47:0] omu_d, ad_mul, ad_rnd;
	logic signed [47:0] r_mul, r_sum;
	logic [15:0]        r_new;
	logic [47:0]        g_mul, g_rnd;
	logic [15:0]        g_sat;
	logic signed [47:0] neg_sum, pos_sum;
	logic [15:0]        neg_base, pos_base;
	logic               out_free, commit;

	always_comb begin
		omu_f  = 48'sd32768 - $signed({32'd0, base_q});
		af_mul = omu_f * $signed({32'd0, fu_q});
		af_rnd = rnd_shr(af_mul, 15);

		fu_mul = 48'(af_q) * $signed({31'd0, ef});
		fu_sum = $signed({32'd0, base_q}) + rnd_shr(fu_mul, 16);
		if (fu_sum < 0)
			fu_new = '0;
		else if (fu_sum > 48'sd65535)
			fu_new = 16'hFFFF;
		else
			fu_new = fu_sum[15:0];

		omu_d  = 48'sd32768 - $signed({32'd0, eu_q});
		ad_mul = $signed({32'd0, res_q}) * omu_d;
		ad_rnd = rnd_shr(ad_mul, 15) - 48'sd32768;

		r_mul = 48'(ad_q) * $signed({31'd0, ed});
		r_sum = 48'sd32768 + rnd_shr(r_mul, 16);
		if (r_sum < 0)
			r_new = '0;
		else if (r_sum > 48'sd32768)
			r_new = 16'(Q15_ONE);
		else
			r_new = r_sum[15:0];

		g_mul = 48'(p_q) * 48'(max_g_q);
		g_rnd = (g_mul + (48'd1 << 29)) >> 30;
		g_sat = (|g_rnd[47:16]) ? 16'hFFFF : g_rnd[15:0];

		neg_sum = $signed({32'd0, base_q}) + 48'(neg_rd_q);
		if (neg_sum < 0)
			neg_base = '0;
		else if (neg_sum > 48'sd65535)
			neg_base = 16'hFFFF;
		else
			neg_base = neg_sum[15:0];

		pos_sum = $signed({32'd0, base_q}) + 48'(pos_rd_q);
		if (pos_sum < 0)
			pos_base = '0;
		else if (pos_sum > 48'sd32768)
			pos_base = 16'(Q15_ONE);
		else
			pos_base = pos_sum[15:0];
	end

	assign out_free = !m_tvalid || m_tready;
	assign commit   = (state_q == ST_G2) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_op == OP_SPIKE)
					state_d = ST_EXP1;
				else if (in_acc && in_op == OP_FIRE)
					state_d = ST_POS_RD;
			end
			ST_POS_RD:  state_d = ST_POS_UPD;
			ST_POS_UPD: state_d = ST_IDLE;
			ST_EXP1:    state_d = ST_EXP2;
			ST_EXP2:    state_d = ST_FAC1;
			ST_FAC1:    state_d = ST_FAC2;
			ST_FAC2:    state_d = ST_DEP1;
			ST_DEP1:    state_d = ST_DEP2;
			ST_DEP2:    state_d = ST_G1;
			ST_G1:      state_d = ST_G2;
			ST_G2: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// capture the item and stage the spike arithmetic
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ts_q      <= in_ts;
			dt_q      <= dt_now;
			dlf_q     <= dlf_now;
			neg_hit_q <= neg_en_q && !dlf_now[32]
				&& dlf_now[31:0] < 32'(neg_win_q)
				&& dlf_now[31:0] < 32'(LEARN_TABLE_DEPTH);
			pos_hit_q <= pos_en_q && !flag_q && !dt_now[32]
				&& dt_now[31:0] < 32'(pos_win_q)
				&& dt_now[31:0] < 32'(LEARN_TABLE_DEPTH);
		end
		if (state_q == ST_FAC1)
			af_q <= af_rnd[19:0];
		if (state_q == ST_FAC2)
			eu_q <= mode_q[1] ? fu_new : base_q;
		if (state_q == ST_DEP1)
			ad_q <= ad_rnd[19:0];
		if (state_q == ST_DEP2)
			rn_q <= mode_q[0] ? r_new : 16'(Q15_ONE);
		if (state_q == ST_G1)
			p_q <= 32'(eu_q) * 32'(rn_q);
		if (commit)
			m_tdata <= {rn_q, eu_q, g_sat};
	end

	// result valid: set on commit, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (commit)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	// synapse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			fu_q   <= '0;
			res_q  <= '0;
			prev_q <= '0;
			flag_q <= 1'b0;
		end else if (in_acc && in_op == OP_INIT) begin
			base_q <= (in_iu > 16'(Q15_ONE)) ? 16'(Q15_ONE) : in_iu;
			fu_q   <= (in_iu > 16'(Q15_ONE)) ? 16'(Q15_ONE) : in_iu;
			res_q  <= (in_ir > 16'(Q15_ONE)) ? 16'(Q15_ONE) : in_ir;
			prev_q <= in_ts;
			flag_q <= 1'b0;
		end else if (state_q == ST_POS_UPD && pos_hit_q) begin
			base_q <= pos_base;
			flag_q <= 1'b1;
		end else if (commit) begin
			if (mode_q[1])
				fu_q <= eu_q;
			if (mode_q[0])
				res_q <= rn_q;
			if (neg_hit_q)
				base_q <= neg_base;
			prev_q <= ts_q;
			flag_q <= 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			max_g_q    <= '0;
			dep_rate_q <= '0;
			fac_rate_q <= '0;
			neg_en_q   <= 1'b0;
			pos_en_q   <= 1'b0;
			neg_win_q  <= '0;
			pos_win_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:     mode_q     <= cfg_data[1:0];
				REG_MAX_G:    max_g_q    <= cfg_data;
				REG_DEP_RATE: dep_rate_q <= cfg_data;
				REG_FAC_RATE: fac_rate_q <= cfg_data;
				REG_NEG_EN:   neg_en_q   <= cfg_data[0];
				REG_POS_EN:   pos_en_q   <= cfg_data[0];
				REG_NEG_WIN:  neg_win_q  <= cfg_data[8:0];
				REG_POS_WIN:  pos_win_q  <= cfg_data[8:0];
				default:      ;
			endcase
		end
	end

	// a result appears only after the last spike step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_G2)
		else $error("result raised outside the final spike step");

	// the resource never leaves [0, 1.0]
	assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= 16'(Q15_ONE))
		else $error("resource above 1.0");

	// an accepted spike starts the exp stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_op == OP_SPIKE) |=> state_q == ST_EXP1)
		else $error("spike did not enter the exp stage");

	// positive learning leaves the base utilisation at or below 1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POS_UPD && pos_hit_q) |=> base_q <= 16'(Q15_ONE))
		else $error("positive learning exceeded 1.0");

endmodule
`default_nettype wire

FILE: rtl/core/dse_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dse_exp: two-stage exp(-dt*rate) factor unit
// Stage 1 forms x = dt*rate in Q32.16, stage 2 looks up the integer and
// fraction tables and multiplies them into a Q16 factor, 1.0 if dt < 0.
// ----------------------------------------------------------------------------
module dse_exp
	import dse_pkg::*;
#(
	parameter int unsigned EXP_FRAC_ENTRIES = EXP_FRAC_DEF
) (
	input  wire logic               clk,
	input  wire logic signed [32:0] dt,
	input  wire logic        [15:0] rate,
	output      logic        [16:0] factor
);

	localparam int unsigned FW = $clog2(EXP_FRAC_ENTRIES);

	logic [16:0] frac_rom [EXP_FRAC_ENTRIES];

	for (genvar g = 0; g < EXP_FRAC_ENTRIES; g++) begin : g_rom
		localparam logic [16:0] FV = frac_entry(EXP_FRAC_ENTRIES, g);
		assign frac_rom[g] = FV;
	end

	logic        neg_s1;
	logic [47:0] x_s1;
	logic [28:0] fprod;
	logic [FW-1:0] fidx;
	logic [33:0] eprod;
	logic [33:0] erounded;

	always_ff @(posedge clk) begin
		neg_s1 <= dt[32];
		x_s1   <= 48'(dt[31:0]) * 48'(rate);
	end

	assign fprod    = 29'(x_s1[15:0]) * 29'(EXP_FRAC_ENTRIES);
	assign fidx     = fprod[16 +: FW];
	assign eprod    = 34'(int_exp(x_s1[19:16])) * 34'(frac_rom[fidx]);
	assign erounded = eprod + 34'd32768;

	always_ff @(posedge clk) begin
		if (neg_s1)
			factor <= 17'd65536;
		else if (|x_s1[47:20])
			factor <= '0;
		else
			factor <= erounded[32:16];
	end

endmodule
`default_nettype wire
